// ----- hdl/sitg_pkg.sv -----
package sitg_pkg;

  localparam int unsigned MAX_SECTORS = 64;
  localparam int unsigned SLOT_W      = $clog2(MAX_SECTORS);
  localparam int unsigned COUNT_W     = SLOT_W + 1;
  localparam int unsigned CYL_W       = 8;
  localparam int unsigned STEP_W      = 6;
  localparam int unsigned SKEW_W      = 6;
  localparam int unsigned OFFSET_W    = 8;
  localparam int unsigned FIRST_W     = 8;
  localparam int unsigned ID_W        = 9;
  localparam int unsigned PROD_W      = SKEW_W + CYL_W;
  localparam int unsigned DIV_W       = PROD_W + 1;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_W);
  localparam int unsigned PC_W        = 4;
  localparam int unsigned REG_IDX_W   = 3;
  localparam int unsigned REG_DATA_W  = 8;

  localparam logic [REG_IDX_W-1:0] REG_SECTOR_COUNT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTERLEAVE_STEP = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CYLINDER_SKEW   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_START_OFFSET    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_ID        = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_MUL,
    OP_LOAD_BASE,
    OP_DIV,
    OP_LOAD_STEP,
    OP_INIT_PLACE,
    OP_PLACE,
    OP_INIT_EMIT,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_START,
    COND_N_ZERO,
    COND_DIV_MORE,
    COND_PLACE_MORE,
    COND_EMIT_MORE
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  typedef struct packed {
    logic n_zero;
    logic div_more;
    logic taken;
    logic not_last;
  } status_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  sector_count;
    logic [STEP_W-1:0]   interleave_step;
    logic [SKEW_W-1:0]   cylinder_skew;
    logic [OFFSET_W-1:0] start_offset;
    logic [FIRST_W-1:0]  first_id;
  } cfg_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_DIV_A = 4'd3;
  localparam logic [PC_W-1:0] PC_DIV_B = 4'd5;
  localparam logic [PC_W-1:0] PC_PLACE = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT  = 4'd9;

  function automatic ctrl_t microcode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      4'd0:    w = '{op: OP_LATCH,      cond: COND_NOT_START,  target: PC_IDLE};
      4'd1:    w = '{op: OP_MUL,        cond: COND_N_ZERO,     target: PC_IDLE};
      4'd2:    w = '{op: OP_LOAD_BASE,  cond: COND_NEVER,      target: PC_IDLE};
      4'd3:    w = '{op: OP_DIV,        cond: COND_DIV_MORE,   target: PC_DIV_A};
      4'd4:    w = '{op: OP_LOAD_STEP,  cond: COND_NEVER,      target: PC_IDLE};
      4'd5:    w = '{op: OP_DIV,        cond: COND_DIV_MORE,   target: PC_DIV_B};
      4'd6:    w = '{op: OP_INIT_PLACE, cond: COND_NEVER,      target: PC_IDLE};
      4'd7:    w = '{op: OP_PLACE,      cond: COND_PLACE_MORE, target: PC_PLACE};
      4'd8:    w = '{op: OP_INIT_EMIT,  cond: COND_NEVER,      target: PC_IDLE};
      4'd9:    w = '{op: OP_EMIT,       cond: COND_EMIT_MORE,  target: PC_EMIT};
      default: w = '{op: OP_NONE,       cond: COND_ALWAYS,     target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/sitg_ram.sv -----
module sitg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/sitg_seq.sv -----
module sitg_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sitg_pkg::status_t status,
  output sitg_pkg::ctrl_t  ctrl,
  output logic             busy
);

  logic [sitg_pkg::PC_W-1:0] pc;
  logic [sitg_pkg::PC_W-1:0] pc_next;
  logic                      jump;

  assign ctrl = sitg_pkg::microcode(pc);
  assign busy = (pc != sitg_pkg::PC_IDLE);

  always_comb begin
    case (ctrl.cond)
      sitg_pkg::COND_NEVER:      jump = 1'b0;
      sitg_pkg::COND_ALWAYS:     jump = 1'b1;
      sitg_pkg::COND_NOT_START:  jump = !start;
      sitg_pkg::COND_N_ZERO:     jump = status.n_zero;
      sitg_pkg::COND_DIV_MORE:   jump = status.div_more;
      sitg_pkg::COND_PLACE_MORE: jump = status.taken || status.not_last;
      sitg_pkg::COND_EMIT_MORE:  jump = status.not_last;
      default:                   jump = 1'b1;
    endcase
    pc_next = jump ? ctrl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= sitg_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- hdl/sitg_datapath.sv -----
module sitg_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [sitg_pkg::CYL_W-1:0]      cylinder,
  input  sitg_pkg::cfg_t                  cfg,
  input  sitg_pkg::ctrl_t                 ctrl,
  output sitg_pkg::status_t               status,
  output logic                            result_strobe,
  output logic [sitg_pkg::SLOT_W-1:0]     slot_index,
  output logic [sitg_pkg::ID_W-1:0]       sector_id,
  output logic                            last_slot
);

  localparam int unsigned SW = sitg_pkg::SLOT_W;
  localparam int unsigned NW = sitg_pkg::COUNT_W;
  localparam int unsigned DW = sitg_pkg::DIV_W;

  logic [sitg_pkg::CYL_W-1:0]     cyl;
  logic [NW-1:0]                  n;
  logic [sitg_pkg::PROD_W-1:0]    prod;
  logic [DW-1:0]                  div;
  logic [SW-1:0]                  rem;
  logic [sitg_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [SW-1:0]                  base;
  logic [SW-1:0]                  step_mod;
  logic [SW-1:0]                  aim;
  logic [SW-1:0]                  pos;
  logic [SW-1:0]                  idx;
  logic [sitg_pkg::MAX_SECTORS-1:0] taken;

  logic [NW-1:0]           n_eff;
  logic [DW:0]             dividend;
  logic [NW-1:0]           shifted;
  logic [SW-1:0]           rem_next;
  logic [NW-1:0]           aim_sum;
  logic [SW-1:0]           aim_next;
  logic [NW-1:0]           pos_inc;
  logic [SW-1:0]           pos_next;
  logic                    is_last;
  logic                    ram_we;
  logic [SW-1:0]           ram_raddr;
  logic [sitg_pkg::ID_W-1:0] ram_wdata;
  logic [sitg_pkg::ID_W-1:0] ram_rdata;

  always_comb begin
    n_eff = (cfg.sector_count > NW'(sitg_pkg::MAX_SECTORS)) ?
            NW'(sitg_pkg::MAX_SECTORS) : cfg.sector_count;
    dividend = {2'b00, prod}
             + {{(DW + 1 - sitg_pkg::OFFSET_W){cfg.start_offset[sitg_pkg::OFFSET_W-1]}},
                cfg.start_offset}
             + {2'b00, n, 7'b0000000};
    shifted  = {rem, div[DW-1]};
    rem_next = (shifted >= n) ? SW'(shifted - n) : shifted[SW-1:0];
    aim_sum  = {1'b0, aim} + {1'b0, step_mod};
    aim_next = (aim_sum >= n) ? SW'(aim_sum - n) : aim_sum[SW-1:0];
    pos_inc  = {1'b0, pos} + 1'b1;
    pos_next = (pos_inc == n) ? '0 : pos_inc[SW-1:0];
    is_last  = ({1'b0, idx} == n - 1'b1);
    ram_we    = (ctrl.op == sitg_pkg::OP_PLACE) && !taken[pos];
    ram_wdata = {1'b0, cfg.first_id} + {{(sitg_pkg::ID_W - SW){1'b0}}, idx};
    ram_raddr = (ctrl.op == sitg_pkg::OP_INIT_EMIT) ? '0 : idx + 1'b1;
  end

  assign status.n_zero   = (n == '0);
  assign status.div_more = (div_cnt != '0);
  assign status.taken    = taken[pos];
  assign status.not_last = !is_last;

  sitg_ram #(
    .WIDTH(sitg_pkg::ID_W),
    .DEPTH(sitg_pkg::MAX_SECTORS)
  ) u_slot_ids (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pos),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    case (ctrl.op)
      sitg_pkg::OP_LATCH: begin
        if (start) begin
          cyl <= cylinder;
          n   <= n_eff;
        end
      end
      sitg_pkg::OP_MUL: begin
        prod <= cfg.cylinder_skew * cyl;
      end
      sitg_pkg::OP_LOAD_BASE: begin
        div     <= dividend[DW-1:0];
        rem     <= '0;
        div_cnt <= sitg_pkg::DIV_CNT_W'(DW - 1);
      end
      sitg_pkg::OP_DIV: begin
        rem     <= rem_next;
        div     <= {div[DW-2:0], 1'b0};
        div_cnt <= div_cnt - 1'b1;
      end
      sitg_pkg::OP_LOAD_STEP: begin
        base    <= rem;
        div     <= DW'(cfg.interleave_step);
        rem     <= '0;
        div_cnt <= sitg_pkg::DIV_CNT_W'(DW - 1);
      end
      sitg_pkg::OP_INIT_PLACE: begin
        step_mod <= rem;
        aim      <= base;
        pos      <= base;
        idx      <= '0;
        taken    <= '0;
      end
      sitg_pkg::OP_PLACE: begin
        if (taken[pos]) begin
          pos <= pos_next;
        end else begin
          taken[pos] <= 1'b1;
          aim        <= aim_next;
          pos        <= aim_next;
          idx        <= idx + 1'b1;
        end
      end
      sitg_pkg::OP_INIT_EMIT: begin
        idx <= '0;
      end
      sitg_pkg::OP_EMIT: begin
        idx <= idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (ctrl.op == sitg_pkg::OP_EMIT);
    end
    slot_index <= idx;
    sector_id  <= ram_rdata;
    last_slot  <= is_last;
  end

endmodule

// ----- hdl/sector_interleave_table_generator_unit.sv -----
// After the start transfer the unit latches, multiplies, divides twice, places and emits; n is the
// effective sector count, and placement takes one step per sector plus one per collision probe,
// at most n*(n+1)/2 steps. Results come one per cycle in slot order, set by the RAM read.
// A new track is not taken while one is in progress; the next start is taken when busy falls.
// Reset: synchronous, restores register defaults and returns the sequencer to idle.
// The receiver cannot stall: each result strobe lasts one cycle.
module sector_interleave_table_generator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [sitg_pkg::CYL_W-1:0]          cylinder,
  output logic                                result_strobe,
  output logic [sitg_pkg::SLOT_W-1:0]         slot_index,
  output logic [sitg_pkg::ID_W-1:0]           sector_id,
  output logic                                last_slot,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sitg_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [sitg_pkg::REG_DATA_W-1:0]     cfg_data
);

  sitg_pkg::cfg_t    cfg;
  sitg_pkg::ctrl_t   ctrl;
  sitg_pkg::status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sector_count    <= sitg_pkg::COUNT_W'(9);
      cfg.interleave_step <= sitg_pkg::STEP_W'(1);
      cfg.cylinder_skew   <= '0;
      cfg.start_offset    <= '0;
      cfg.first_id        <= sitg_pkg::FIRST_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sitg_pkg::REG_SECTOR_COUNT:    cfg.sector_count    <= cfg_data[sitg_pkg::COUNT_W-1:0];
        sitg_pkg::REG_INTERLEAVE_STEP: cfg.interleave_step <= cfg_data[sitg_pkg::STEP_W-1:0];
        sitg_pkg::REG_CYLINDER_SKEW:   cfg.cylinder_skew   <= cfg_data[sitg_pkg::SKEW_W-1:0];
        sitg_pkg::REG_START_OFFSET:    cfg.start_offset    <= cfg_data;
        sitg_pkg::REG_FIRST_ID:        cfg.first_id        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sitg_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  sitg_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cylinder     (cylinder),
    .cfg          (cfg),
    .ctrl         (ctrl),
    .status       (status),
    .result_strobe(result_strobe),
    .slot_index   (slot_index),
    .sector_id    (sector_id),
    .last_slot    (last_slot)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy)
    else $error("result strobe outside a busy period");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last_slot |=> !result_strobe && !busy)
    else $error("results continue after the last slot");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start transfer");

  a_first_slot: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !$past(result_strobe) |-> slot_index == '0)
    else $error("track does not begin at slot zero");

endmodule
